>>> rtl/sltt_pkg.sv
// Shared types, character codes and the operator lookup function for the token transcoder.
package sltt_pkg;

  localparam int MAX_COMMENT_DEPTH = 255;
  localparam int DepthW = $clog2(MAX_COMMENT_DEPTH + 1) + 1;
  localparam int MaxBytes = 7;
  localparam int CountW = $clog2(MaxBytes + 1);

  localparam logic [7:0] ChEnd      = 8'hFF;
  localparam logic [7:0] ChOpenBr   = 8'h7B;
  localparam logic [7:0] ChCloseBr  = 8'h7D;
  localparam logic [7:0] ChQuote    = 8'h22;
  localparam logic [7:0] ChOpenSq   = 8'h5B;
  localparam logic [7:0] ChCloseSq  = 8'h5D;
  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChLf       = 8'h0A;
  localparam logic [7:0] ChCr       = 8'h0D;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam logic [7:0] ChSemi     = 8'h3B;
  localparam logic [7:0] ChComma    = 8'h2C;
  localparam logic [7:0] ChAo       = 8'hF8;
  localparam logic [7:0] ChAb       = 8'hDF;
  localparam logic [7:0] ChLParen   = 8'h28;
  localparam logic [7:0] ChRParen   = 8'h29;
  localparam logic [7:0] ChMinus    = 8'h2D;
  localparam logic [7:0] ChZero     = 8'h30;
  localparam logic [7:0] ChOne      = 8'h31;
  localparam logic [7:0] ChBslash   = 8'h5C;
  localparam logic [7:0] ChColon    = 8'h3A;
  localparam logic [7:0] ChTilde    = 8'h7E;
  localparam logic [7:0] ChUnder    = 8'h5F;
  localparam logic [7:0] ChEqual    = 8'h3D;
  localparam logic [7:0] ChLowS     = 8'h73;
  localparam logic [7:0] ChLowC     = 8'h63;
  localparam logic [7:0] ChLowA     = 8'h61;
  localparam logic [7:0] ChLowO     = 8'h6F;
  localparam logic [7:0] ChLowB     = 8'h62;
  localparam logic [7:0] ChLowZ     = 8'h7A;
  localparam logic [7:0] ChNine     = 8'h39;

  // Expansion of one source byte: up to seven output bytes, entry 0 first.
  typedef struct packed {
    logic [CountW-1:0]            count;
    logic [MaxBytes-1:0][7:0]     bytes;
  } xlate_t;

  typedef struct packed {
    logic       is_op;
    logic       two;
    logic [7:0] c0;
    logic [7:0] c1;
  } op_tok_t;

  function automatic op_tok_t operator_token(input logic [7:0] b);
    op_tok_t t;
    t = '{is_op: 1'b1, two: 1'b0, c0: b, c1: b};
    case (b)
      ChColon:  begin t.two = 1'b1; t.c0 = ChBslash; t.c1 = ChColon; end
      ChTilde:  begin t.two = 1'b1; t.c0 = ChBslash; t.c1 = ChTilde; end
      ChBslash: begin t.two = 1'b1; t.c0 = ChBslash; t.c1 = ChBslash; end
      ChUnder:  t.c0 = ChMinus;
      ChEqual:  begin t.two = 1'b1; t.c0 = ChEqual; t.c1 = ChEqual; end
      8'h21, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3E, 8'h26, 8'h7C,
      8'h24, 8'h25, 8'h40, 8'h3F, 8'h23, 8'h2E, 8'h5E: t.is_op = 1'b1;
      default:  t.is_op = 1'b0;
    endcase
    return t;
  endfunction

endpackage

>>> rtl/stack_language_token_transcoder.sv
// Top level of the token transcoder: input handshake, expander and output shift buffer.
// Each accepted source byte is expanded in the same cycle into zero to seven output
// words, which are loaded into a seven-entry output shift buffer and delivered one per
// cycle unless out_stall_i is high, the final word of each byte marked by last_of_run_o.
// A byte of one word or none sustains one input byte per cycle while the output is not
// stalled; a longer expansion holds the input, as the next byte is taken only in the
// cycle the final word leaves. Bytes with no output are accepted on the same terms.
// After an end byte (0xFF) every further byte is accepted and ignored until reset.
module stack_language_token_transcoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);
  import sltt_pkg::*;

  xlate_t                   word;
  logic [MaxBytes-1:0][7:0] buf_q, buf_d;
  logic [CountW-1:0]        rem_q, rem_d;
  logic                     in_accept;
  logic                     out_take;

  sltt_xlate u_xlate (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (in_byte_i),
    .word_o   (word)
  );

  assign out_valid_o   = (rem_q != '0);
  assign out_byte_o    = buf_q[0];
  assign last_of_run_o = (rem_q == CountW'(1));
  assign out_take      = out_valid_o && !out_stall_i;
  // Input waits until the buffer is empty or its final word leaves now.
  assign in_stall_o    = (rem_q > CountW'(1)) || (last_of_run_o && out_stall_i);
  assign in_accept     = in_valid_i && !in_stall_o;

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    if (out_take) begin
      buf_d = {8'h00, buf_q[MaxBytes-1:1]};
      rem_d = rem_q - 1'b1;
    end
    if (in_accept && word.count != '0) begin
      buf_d = word.bytes;
      rem_d = word.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

>>> rtl/sltt_xlate.sv
// Parser state and the combinational expansion of one source byte into output bytes.
module sltt_xlate (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            byte_i,
  output sltt_pkg::xlate_t      word_o
);
  import sltt_pkg::*;

  localparam logic signed [DepthW-1:0] DepthMax = DepthW'(MAX_COMMENT_DEPTH);

  logic signed [DepthW-1:0] depth_q, depth_d;
  logic in_string_q, in_string_d;
  logic in_run_q, in_run_d;
  logic sep_q, sep_d;
  logic stopped_q, stopped_d;

  always_comb begin
    logic [MaxBytes-1:0][7:0] bufv;
    logic [CountW-1:0]        n;
    op_tok_t                  tok;
    logic [7:0]               mag;
    logic                     hund;
    logic [6:0]               rem;
    logic [17:0]              prod;
    logic [3:0]               tens;
    logic [3:0]               ones;
    logic                     sets_sep;

    bufv        = '0;
    n           = '0;
    depth_d     = depth_q;
    in_string_d = in_string_q;
    in_run_d    = in_run_q;
    sep_d       = sep_q;
    stopped_d   = stopped_q;
    sets_sep    = 1'b1;
    tok         = operator_token(byte_i);

    // Magnitude of the byte read as a signed number, split into decimal digits.
    mag  = byte_i[7] ? (~byte_i + 8'd1) : byte_i;
    hund = (mag >= 8'd100);
    rem  = hund ? 7'(mag - 8'd100) : mag[6:0];
    prod = 18'(rem) * 18'd205;
    tens = prod[14:11];
    ones = 4'(rem - 7'(tens) * 7'd10);

    if (stopped_q) begin
    end else if (byte_i == ChEnd) begin
      stopped_d = 1'b1;
    end else if (byte_i == ChOpenBr) begin
      if (depth_q < DepthMax) depth_d = depth_q + 1'b1;
    end else if (byte_i == ChCloseBr) begin
      if (depth_q > -DepthMax) depth_d = depth_q - 1'b1;
    end else if (depth_q > 0) begin
    end else if (in_string_q && byte_i != ChQuote) begin
      bufv[n] = byte_i; n = n + 1'b1;
    end else if (byte_i >= ChLowA && byte_i <= ChLowZ) begin
      if (sep_q) begin
        bufv[n] = ChComma; n = n + 1'b1;
        bufv[n] = ChSpace; n = n + 1'b1;
      end
      bufv[n] = byte_i; n = n + 1'b1;
    end else if (byte_i >= ChZero && byte_i <= ChNine) begin
      if (sep_q && !in_run_q) begin
        bufv[n] = ChComma; n = n + 1'b1;
        bufv[n] = ChSpace; n = n + 1'b1;
      end
      bufv[n] = byte_i; n = n + 1'b1;
      in_run_d = 1'b1;
    end else begin
      in_run_d = 1'b0;
      if (byte_i == ChQuote) begin
        in_string_d = !in_string_q;
        if (!in_string_q && sep_q) begin
          bufv[n] = ChComma; n = n + 1'b1;
          bufv[n] = ChSpace; n = n + 1'b1;
        end
        bufv[n] = ChQuote; n = n + 1'b1;
      end else if (byte_i == ChOpenSq) begin
        if (sep_q) begin
          bufv[n] = ChComma; n = n + 1'b1;
          bufv[n] = ChSpace; n = n + 1'b1;
        end
        bufv[n] = ChSpace;  n = n + 1'b1;
        bufv[n] = ChOpenSq; n = n + 1'b1;
        bufv[n] = ChSpace;  n = n + 1'b1;
        sep_d    = 1'b0;
        sets_sep = 1'b0;
      end else if (byte_i == ChCloseSq) begin
        bufv[n] = ChCloseSq; n = n + 1'b1;
        sets_sep = 1'b0;
      end else if (byte_i == ChSpace || byte_i == ChLf || byte_i == ChCr) begin
        bufv[n] = ChSpace; n = n + 1'b1;
        sets_sep = 1'b0;
      end else if (byte_i == ChTab) begin
        bufv[n] = ChTab; n = n + 1'b1;
        sets_sep = 1'b0;
      end else begin
        if (sep_q) begin
          bufv[n] = ChComma; n = n + 1'b1;
          bufv[n] = ChSpace; n = n + 1'b1;
        end
        if (byte_i == ChSemi || byte_i == ChComma || byte_i == ChAo || byte_i == ChAb) begin
          bufv[n] = ChSpace; n = n + 1'b1;
          case (byte_i)
            ChSemi:  begin bufv[n] = ChLowS; n = n + 1'b1; bufv[n] = ChLowC; end
            ChComma: begin bufv[n] = ChLowC; n = n + 1'b1; bufv[n] = ChLowC; end
            ChAo:    begin bufv[n] = ChLowA; n = n + 1'b1; bufv[n] = ChLowO; end
            default: begin bufv[n] = ChLowA; n = n + 1'b1; bufv[n] = ChLowB; end
          endcase
          n = n + 1'b1;
        end else if (tok.is_op) begin
          bufv[n] = ChLParen; n = n + 1'b1;
          bufv[n] = tok.c0;   n = n + 1'b1;
          if (tok.two) begin
            bufv[n] = tok.c1; n = n + 1'b1;
          end
          bufv[n] = ChRParen; n = n + 1'b1;
          bufv[n] = ChSpace;  n = n + 1'b1;
        end else begin
          if (byte_i[7]) begin
            bufv[n] = ChMinus; n = n + 1'b1;
          end
          if (hund) begin
            bufv[n] = ChOne; n = n + 1'b1;
          end
          if (hund || tens != 4'd0) begin
            bufv[n] = ChZero + 8'(tens); n = n + 1'b1;
          end
          bufv[n] = ChZero + 8'(ones); n = n + 1'b1;
        end
      end
      if (sets_sep) sep_d = 1'b1;
    end

    word_o.bytes = bufv;
    word_o.count = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= '0;
      in_string_q <= 1'b0;
      in_run_q    <= 1'b0;
      sep_q       <= 1'b0;
      stopped_q   <= 1'b0;
    end else if (accept_i) begin
      depth_q     <= depth_d;
      in_string_q <= in_string_d;
      in_run_q    <= in_run_d;
      sep_q       <= sep_d;
      stopped_q   <= stopped_d;
    end
  end

endmodule

>>> tb/sltt_tb_pkg.sv
// Scoreboard class that predicts and checks the transcoder's output words.
`timescale 1ns / 1ps
package sltt_tb_pkg;
  import sltt_pkg::*;

  class text_expansion_board;
    int depth;
    bit quoted;
    bit digit_run;
    bit comma_due;
    bit halted;
    int errors;
    bit [7:0] pending_text[$];
    bit pending_last[$];
    bit [7:0] burst[$];

    function new();
      depth = 0;
      quoted = 1'b0;
      digit_run = 1'b0;
      comma_due = 1'b0;
      halted = 1'b0;
      errors = 0;
    endfunction

    function void put(bit [7:0] c);
      if (burst.size() < MaxBytes) begin
        burst.push_back(c);
      end
    endfunction

    function void put_text(string s);
      for (int i = 0; i < s.len(); i++) begin
        put(s[i]);
      end
    endfunction

    function void put_comma();
      if (comma_due) begin
        put_text(", ");
      end
    endfunction

    function bit op_token(input bit [7:0] b, output string tok);
      tok = "";
      case (b)
        ChColon:  tok = "\\:";
        ChTilde:  tok = "\\~";
        ChBslash: tok = "\\\\";
        ChUnder:  tok = "-";
        ChEqual:  tok = "==";
        "!", "+", "-", "*", "/", ">", "&", "|", "$", "%", "@", "?", "#", ".", "^": begin
          tok = $sformatf("%c", b);
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // The byte is read as a signed 8-bit value.
    function void put_decimal(bit [7:0] b);
      int mag;
      mag = b;
      if (b[7]) begin
        put(ChMinus);
        mag = 256 - mag;
      end
      if (mag >= 100) begin
        put(8'(ChZero + mag / 100));
      end
      if (mag >= 10) begin
        put(8'(ChZero + (mag / 10) % 10));
      end
      put(8'(ChZero + mag % 10));
    endfunction

    // Works out the words that one accepted source byte should cause.
    function void note_source_byte(bit [7:0] b);
      string tok;
      bit is_op;
      bit marks;
      burst.delete();
      if (halted) begin
        return;
      end
      if (b == ChEnd) begin
        halted = 1'b1;
        return;
      end
      if (b == ChOpenBr) begin
        if (depth < MAX_COMMENT_DEPTH) depth++;
        return;
      end
      if (b == ChCloseBr) begin
        if (depth > -MAX_COMMENT_DEPTH) depth--;
        return;
      end
      if (depth > 0) begin
        return;
      end
      if (quoted && b != ChQuote) begin
        put(b);
      end else if (b >= ChLowA && b <= ChLowZ) begin
        put_comma();
        put(b);
      end else if (b >= ChZero && b <= ChNine) begin
        if (!digit_run) put_comma();
        put(b);
        digit_run = 1'b1;
      end else begin
        marks = 1'b1;
        digit_run = 1'b0;
        is_op = op_token(b, tok);
        case (b)
          ChQuote: begin
            quoted = !quoted;
            if (quoted) put_comma();
            put(ChQuote);
          end
          ChOpenSq: begin
            put_comma();
            put_text(" [ ");
            comma_due = 1'b0;
            marks = 1'b0;
          end
          ChCloseSq: begin
            put(ChCloseSq);
            marks = 1'b0;
          end
          ChSpace, ChLf, ChCr: begin
            put(ChSpace);
            marks = 1'b0;
          end
          ChTab: begin
            put(ChTab);
            marks = 1'b0;
          end
          ChSemi: begin
            put_comma();
            put_text(" sc");
          end
          ChComma: begin
            put_comma();
            put_text(" cc");
          end
          ChAo: begin
            put_comma();
            put_text(" ao");
          end
          ChAb: begin
            put_comma();
            put_text(" ab");
          end
          default: begin
            put_comma();
            if (is_op) begin
              put(ChLParen);
              put_text(tok);
              put_text(") ");
            end else begin
              put_decimal(b);
            end
          end
        endcase
        if (marks) comma_due = 1'b1;
      end
      foreach (burst[i]) begin
        pending_text.push_back(burst[i]);
        pending_last.push_back(i == burst.size() - 1);
      end
    endfunction

    function void check_text_word(logic [7:0] w, logic last);
      bit [7:0] want;
      bit want_last;
      if (pending_text.size() == 0) begin
        $error("unexpected word: out_byte 0x%02h, last_of_run %b", w, last);
        errors++;
        return;
      end
      want = pending_text.pop_front();
      want_last = pending_last.pop_front();
      if (w !== want) begin
        $error("out_byte: expected 0x%02h, actual 0x%02h", want, w);
        errors++;
      end
      if (last !== want_last) begin
        $error("last_of_run: expected %b, actual %b", want_last, last);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> tb/stack_language_token_transcoder_test.sv
// Top-level testbench of the token transcoder: stimulus, backpressure and end of run.
`timescale 1ns / 1ps
module stack_language_token_transcoder_test;
  import sltt_pkg::*;
  import sltt_tb_pkg::*;

  localparam int HalfPeriod = 10;
  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 20;
  localparam int RandomItems = 115;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic [7:0] in_byte_i = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  text_expansion_board board = new();
  bit          calm = 1'b0;
  int unsigned cycles = 0;
  int          sent = 0;

  always #HalfPeriod clk_i = ~clk_i;

  stack_language_token_transcoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      board.note_source_byte(in_byte_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_text_word(out_byte_o, last_of_run_o);
    end
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Output backpressure: free stretches of varied length, then a stall burst while calm is clear.
  initial begin
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(20, 60)) @(negedge clk_i);
      end else begin
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      if (!calm) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the byte is taken.
  task automatic send_byte(bit [7:0] b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_byte_i = b;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic send_repeated(bit [7:0] b, int n);
    repeat (n) send_byte(b);
  endtask

  // Mostly well-formed text: words, numbers, operators, strings and comments,
  // with raw bytes mixed in. The end byte is kept back for the close of the run.
  task automatic send_phrase();
    string ops = ":~\\_=!+-*/>&|$%@?#.^";
    int kind;
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      send_byte(8'($urandom_range(ChLowA, ChLowZ)));
    end else if (kind < 32) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(ChZero, ChNine)));
    end else if (kind < 47) begin
      send_byte(ops[$urandom_range(0, ops.len() - 1)]);
    end else if (kind < 54) begin
      case ($urandom_range(0, 3))
        0: send_byte(ChSpace);
        1: send_byte(ChLf);
        2: send_byte(ChCr);
        default: send_byte(ChTab);
      endcase
    end else if (kind < 62) begin
      case ($urandom_range(0, 3))
        0: send_byte(ChSemi);
        1: send_byte(ChComma);
        2: send_byte(ChAo);
        default: send_byte(ChAb);
      endcase
    end else if (kind < 67) begin
      send_byte($urandom_range(0, 1) ? ChOpenSq : ChCloseSq);
    end else if (kind < 74) begin
      send_byte(ChQuote);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 254)));
      send_byte(ChQuote);
    end else if (kind < 80) begin
      send_byte(ChOpenBr);
      repeat ($urandom_range(0, 4)) send_byte(8'($urandom_range(0, 254)));
      send_byte(ChCloseBr);
    end else begin
      send_byte(8'($urandom_range(0, 254)));
    end
  endtask

  initial begin
    bit [7:0] script[$];
    int first;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Letters, a digit run, each specially mapped operator and every fixed word, signed
    // decimals down to -128, whitespace, brackets, and a comment inside a string.
    script = '{"a", "z", "0", "9", ChColon, "7", ChEqual, ChUnder, ChBslash, ChTilde,
               8'h80, 8'h00, 8'hFE, ChAo, ChAb, ChSemi, ChComma, ChOpenSq, ChCloseSq,
               ChSpace, ChLf, ChCr, ChTab, ChQuote, ChOpenBr, "x", ChCloseBr, "x",
               ChQuote};
    foreach (script[i]) send_byte(script[i]);

    // A negative depth still lets text through; one open brace past zero
    // starts a comment that drops text until it is closed again.
    send_repeated(ChCloseBr, 3);
    send_byte("a");
    send_repeated(ChOpenBr, 4);
    send_byte("a");
    send_byte(ChCloseBr);
    send_byte("a");

    first = sent;
    while (sent - first < RandomItems) begin
      if (sent - first > RandomItems * 3 / 4) calm = 1'b1;
      send_phrase();
    end

    // After the end byte every byte is taken and dropped.
    send_byte(ChEnd);
    repeat (5) send_byte(8'($urandom_range(0, 255)));
    in_valid_i = 1'b0;

    while (board.pending_text.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
